[rtl/mfh_pkg.sv]
// Package for the masked fasthash64 block: constants, state and operation codes,
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package mfh_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned KLEN_W     = 16;
  localparam int unsigned BYTES_PER_WORD = 8;
  localparam int unsigned IN_TDATA_W = 152;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [WORD_W-1:0] HASH_M  = 64'h8803_55f2_1e6d_1965;
  localparam logic [WORD_W-1:0] MIX_MUL = 64'h2127_599b_f432_5c37;
  localparam logic [WORD_W-1:0] SEED    = 64'd3111696;
  localparam int unsigned SHIFT_A = 23;
  localparam int unsigned SHIFT_B = 47;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPLOAD,
    ST_MUL_LL,
    ST_MUL_HL,
    ST_MUL_LH,
    ST_WRITE
  } state_t;

  typedef enum logic [1:0] {
    OP_SEED,
    OP_MIXW,
    OP_HASH,
    OP_MIXH
  } op_t;

  typedef enum logic [1:0] {
    STEP_LL,
    STEP_HL,
    STEP_LH
  } step_t;

  typedef struct packed {
    logic  capture;
    logic  load_ops;
    logic  mul_en;
    step_t step;
    logic  write_back;
    op_t   op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[rtl/mfh_ctrl.sv]
// Controller for the masked fasthash64 block: sequences the seed, absorb and
// final-mix multiplications. Depends on mfh_pkg.
`default_nettype none

module mfh_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_first,
  input  wire logic                        in_last,
  input  wire logic [mfh_pkg::COUNT_W-1:0] in_count,
  input  wire mfh_pkg::status_t            status,
  output mfh_pkg::cmd_t                    cmd
);

  mfh_pkg::state_t state, state_next;
  mfh_pkg::op_t    op, op_next;
  logic            absorb, last;
  logic            in_has_bytes;

  assign in_has_bytes = (in_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mfh_pkg::ST_IDLE;
      op     <= mfh_pkg::OP_SEED;
      absorb <= 1'b0;
      last   <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (state == mfh_pkg::ST_IDLE && in_valid) begin
        absorb <= in_has_bytes;
        last   <= in_last;
      end
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      mfh_pkg::ST_IDLE: begin
        if (in_valid && (in_first || in_has_bytes || in_last)) begin
          state_next = mfh_pkg::ST_OPLOAD;
          if (in_first) begin
            op_next = mfh_pkg::OP_SEED;
          end else if (in_has_bytes) begin
            op_next = mfh_pkg::OP_MIXW;
          end else begin
            op_next = mfh_pkg::OP_MIXH;
          end
        end
      end
      mfh_pkg::ST_OPLOAD: state_next = mfh_pkg::ST_MUL_LL;
      mfh_pkg::ST_MUL_LL: state_next = mfh_pkg::ST_MUL_HL;
      mfh_pkg::ST_MUL_HL: state_next = mfh_pkg::ST_MUL_LH;
      mfh_pkg::ST_MUL_LH: state_next = mfh_pkg::ST_WRITE;
      mfh_pkg::ST_WRITE: begin
        unique case (op)
          mfh_pkg::OP_SEED: begin
            if (absorb) begin
              state_next = mfh_pkg::ST_OPLOAD;
              op_next    = mfh_pkg::OP_MIXW;
            end else if (last) begin
              state_next = mfh_pkg::ST_OPLOAD;
              op_next    = mfh_pkg::OP_MIXH;
            end else begin
              state_next = mfh_pkg::ST_IDLE;
            end
          end
          mfh_pkg::OP_MIXW: begin
            state_next = mfh_pkg::ST_OPLOAD;
            op_next    = mfh_pkg::OP_HASH;
          end
          mfh_pkg::OP_HASH: begin
            if (last) begin
              state_next = mfh_pkg::ST_OPLOAD;
              op_next    = mfh_pkg::OP_MIXH;
            end else begin
              state_next = mfh_pkg::ST_IDLE;
            end
          end
          mfh_pkg::OP_MIXH: begin
            if (status.out_free) begin
              state_next = mfh_pkg::ST_IDLE;
            end
          end
        endcase
      end
      default: state_next = mfh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == mfh_pkg::ST_IDLE);
    cmd.capture    = (state == mfh_pkg::ST_IDLE) && in_valid;
    cmd.load_ops   = (state == mfh_pkg::ST_OPLOAD);
    cmd.mul_en     = 1'b0;
    cmd.step       = mfh_pkg::STEP_LL;
    cmd.write_back = 1'b0;
    cmd.op         = op;
    unique case (state)
      mfh_pkg::ST_MUL_LL: begin
        cmd.mul_en = 1'b1;
        cmd.step   = mfh_pkg::STEP_LL;
      end
      mfh_pkg::ST_MUL_HL: begin
        cmd.mul_en = 1'b1;
        cmd.step   = mfh_pkg::STEP_HL;
      end
      mfh_pkg::ST_MUL_LH: begin
        cmd.mul_en = 1'b1;
        cmd.step   = mfh_pkg::STEP_LH;
      end
      mfh_pkg::ST_WRITE: begin
        cmd.write_back = (op != mfh_pkg::OP_MIXH) || status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/mfh_dp.sv]
// Datapath for the masked fasthash64 block: word masking, running hash, a
// shared 32x32 multiplier for 64-bit products, and the output register.
// Depends on mfh_pkg.
`default_nettype none

module mfh_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mfh_pkg::cmd_t                cmd,
  output mfh_pkg::status_t                  status,
  input  wire logic [mfh_pkg::WORD_W-1:0]   in_data,
  input  wire logic [mfh_pkg::WORD_W-1:0]   in_mask,
  input  wire logic [mfh_pkg::COUNT_W-1:0]  in_count,
  input  wire logic [mfh_pkg::KLEN_W-1:0]   in_klen,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [mfh_pkg::WORD_W-1:0]        out_data
);

  logic [mfh_pkg::WORD_W-1:0] word, hash, opa, opb, acc;
  logic [mfh_pkg::KLEN_W-1:0] klen;
  logic [mfh_pkg::WORD_W-1:0] keep;
  logic [mfh_pkg::HALF_W-1:0] mul_a, mul_b;
  logic [mfh_pkg::WORD_W-1:0] prod;
  logic [mfh_pkg::WORD_W-1:0] acc_next;
  logic [mfh_pkg::WORD_W-1:0] mix_tail;

  // Bytes at or above the valid count are cleared; counts above eight keep all.
  always_comb begin
    for (int i = 0; i < mfh_pkg::BYTES_PER_WORD; i++) begin
      keep[i*8 +: 8] = (in_count[3] || (i < int'(in_count))) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    mul_a = opa[mfh_pkg::HALF_W-1:0];
    mul_b = opb[mfh_pkg::HALF_W-1:0];
    unique case (cmd.step)
      mfh_pkg::STEP_LL: begin
      end
      mfh_pkg::STEP_HL: mul_a = opa[mfh_pkg::WORD_W-1:mfh_pkg::HALF_W];
      mfh_pkg::STEP_LH: mul_b = opb[mfh_pkg::WORD_W-1:mfh_pkg::HALF_W];
      default: begin
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    if (cmd.step == mfh_pkg::STEP_LL) begin
      acc_next = prod;
    end else begin
      acc_next = acc + {prod[mfh_pkg::HALF_W-1:0], {mfh_pkg::HALF_W{1'b0}}};
    end
  end

  assign mix_tail = acc ^ (acc >> mfh_pkg::SHIFT_B);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word <= in_data & in_mask & keep;
      klen <= in_klen;
    end
    if (cmd.load_ops) begin
      unique case (cmd.op)
        mfh_pkg::OP_SEED: begin
          opa <= {{(mfh_pkg::WORD_W-mfh_pkg::KLEN_W){1'b0}}, klen};
          opb <= mfh_pkg::HASH_M;
        end
        mfh_pkg::OP_MIXW: begin
          opa <= word ^ (word >> mfh_pkg::SHIFT_A);
          opb <= mfh_pkg::MIX_MUL;
        end
        mfh_pkg::OP_HASH: begin
          opa <= hash;
          opb <= mfh_pkg::HASH_M;
        end
        mfh_pkg::OP_MIXH: begin
          opa <= hash ^ (hash >> mfh_pkg::SHIFT_A);
          opb <= mfh_pkg::MIX_MUL;
        end
      endcase
    end
    if (cmd.mul_en) begin
      acc <= acc_next;
    end
    if (cmd.write_back && cmd.op == mfh_pkg::OP_MIXH) begin
      out_data <= mix_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.write_back) begin
        unique case (cmd.op)
          mfh_pkg::OP_SEED: hash <= mfh_pkg::SEED ^ acc;
          mfh_pkg::OP_MIXW: hash <= hash ^ mix_tail;
          mfh_pkg::OP_HASH: hash <= acc;
          mfh_pkg::OP_MIXH: begin
          end
        endcase
      end
      if (cmd.write_back && cmd.op == mfh_pkg::OP_MIXH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/masked_fasthash64.sv]
// Masked fasthash64 over a stream of 64-bit key words. Each 64-bit product runs on
// one shared 32x32 multiplier as operand load, three partial products and write-back.
// A word with bytes runs the word-mix and hash products, plus the seed product when
// it is first and the final mix when it is last; an item with nothing to do runs
// none. The result register lets the next beat be accepted while a hash waits.
// Synchronous reset clears the running hash to zero and empties the result register.
// Depends on mfh_pkg, mfh_ctrl and mfh_dp.
`default_nettype none

module masked_fasthash64 (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // data_word, mask_word, bytes_in_word, key_length, zero fill to 152 bits.
  input  wire logic [mfh_pkg::IN_TDATA_W-1:0]    s_tdata,
  // first_word.
  input  wire logic                              s_tuser,
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // hash_value.
  output logic [mfh_pkg::OUT_TDATA_W-1:0]        m_tdata
);

  mfh_pkg::cmd_t    cmd;
  mfh_pkg::status_t status;

  mfh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_first (s_tuser),
    .in_last  (s_tlast),
    .in_count (s_tdata[131:128]),
    .status   (status),
    .cmd      (cmd)
  );

  mfh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata[63:0]),
    .in_mask   (s_tdata[127:64]),
    .in_count  (s_tdata[131:128]),
    .in_klen   (s_tdata[147:132]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

[test/tb_masked_fasthash64.sv]
// Testbench for masked_fasthash64: drives masked key words over the input stream and
// checks every hash beat against a fasthash64 predictor kept in the testbench.
// Depends on mfh_pkg and the masked_fasthash64 RTL.
`timescale 1ns / 1ps

module tb_masked_fasthash64;

  typedef logic [mfh_pkg::WORD_W-1:0]  word_t;
  typedef logic [mfh_pkg::COUNT_W-1:0] count_t;
  typedef logic [mfh_pkg::KLEN_W-1:0]  klen_t;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_BEATS = 1500;
  localparam int unsigned TOTAL_BEATS = 1900;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  // data_word, mask_word, bytes_in_word, key_length, zero fill.
  logic [mfh_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  // first_word.
  logic                            s_tuser = 1'b0;
  logic                            s_tlast = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // hash_value.
  logic [mfh_pkg::OUT_TDATA_W-1:0] m_tdata;

  word_t       key_hash_state = '0;
  word_t       hash_expect_q[$];
  int unsigned beats_sent = 0;
  int unsigned keys_sent = 0;
  int unsigned hashes_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          send_idle_en = 1'b1;
  bit          recv_stall_en = 1'b1;

  masked_fasthash64 DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d hashes pending.", cycle_count,
               hash_expect_q.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic word_t fh_scramble(input word_t x);
    word_t y;
    y = x ^ (x >> mfh_pkg::SHIFT_A);
    y = y * mfh_pkg::MIX_MUL;
    y = y ^ (y >> mfh_pkg::SHIFT_B);
    return y;
  endfunction

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic absorb_key_word(input word_t data, input word_t mask,
                                 input count_t nb, input klen_t klen,
                                 input bit is_first, input bit is_last);
    int unsigned n;
    word_t       keep;
    if (is_first) key_hash_state = mfh_pkg::SEED ^ (64'(klen) * mfh_pkg::HASH_M);
    n = (32'(nb) > mfh_pkg::BYTES_PER_WORD) ? mfh_pkg::BYTES_PER_WORD : 32'(nb);
    if (n != 0) begin
      keep = (n == mfh_pkg::BYTES_PER_WORD) ? '1 : ((64'd1 << (n * 8)) - 64'd1);
      key_hash_state = (key_hash_state ^ fh_scramble(data & mask & keep)) * mfh_pkg::HASH_M;
    end
    if (is_last) hash_expect_q.push_back(fh_scramble(key_hash_state));
  endtask

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    mismatch_count++;
    $display("Mismatch at cycle %0d, %s: got %h, expected %h", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (recv_stall_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (hash_expect_q.size() == 0) begin
        report_mismatch("hash beat with none pending", m_tdata, '0);
      end else begin
        if (m_tdata !== hash_expect_q[0]) report_mismatch("hash_value", m_tdata, hash_expect_q[0]);
        void'(hash_expect_q.pop_front());
        hashes_checked++;
      end
    end
  end

  task automatic send_key_word(input word_t data, input word_t mask,
                               input count_t nb, input klen_t klen,
                               input bit is_first, input bit is_last);
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, klen, nb, mask, data};
    s_tuser <= is_first;
    s_tlast <= is_last;
    do @(posedge clk); while (!s_tready);
    absorb_key_word(data, mask, nb, klen, is_first, is_last);
    beats_sent++;
    if (is_first) keys_sent++;
  endtask

  task automatic wait_all_hashes();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (hash_expect_q.size() != 0);
  endtask

  task automatic send_random_key();
    klen_t       klen;
    int unsigned payload;
    int unsigned nwords;
    int unsigned nb;
    word_t       data;
    word_t       mask;
    if ($urandom_range(0, 9) == 0) begin
      klen = klen_t'($urandom_range(0, 65535));
      payload = klen % 64;
    end else begin
      klen = klen_t'($urandom_range(0, 40));
      payload = klen;
    end
    nwords = (payload == 0) ? 1 : (payload + 7) / 8;
    for (int unsigned i = 0; i < nwords; i++) begin
      nb = (payload == 0) ? 0 : ((payload - 8 * i > 8) ? 8 : payload - 8 * i);
      data = rand64();
      if (nb < 8 && $urandom_range(0, 1) == 0) data &= (64'd1 << (nb * 8)) - 64'd1;
      mask = ($urandom_range(0, 1) == 0) ? '1 : rand64();
      send_key_word(data, mask, nb[mfh_pkg::COUNT_W-1:0], klen, i == 0, i == nwords - 1);
    end
  endtask

  task automatic send_noise_word();
    send_key_word(rand64(), rand64(), count_t'($urandom_range(0, 15)),
                  klen_t'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_directed_cases();
    // Continuing from the reset value without a first mark.
    send_key_word(64'h0123_4567_89ab_cdef, '1, 4'd8, 16'd0, 1'b0, 1'b1);
    // Empty key: seeded and emitted, nothing absorbed.
    send_key_word(rand64(), rand64(), 4'd0, 16'd0, 1'b1, 1'b1);
    send_key_word('1, '1, 4'd8, 16'd8, 1'b1, 1'b1);
    send_key_word('0, '1, 4'd8, 16'd15, 1'b1, 1'b0);
    send_key_word('1, '1, 4'd7, 16'd15, 1'b0, 1'b1);
    // Partial words with junk above the valid bytes in both data and mask.
    for (int unsigned n = 1; n < 8; n++) begin
      send_key_word(rand64(), rand64(), count_t'(n), klen_t'(n), 1'b1, 1'b1);
    end
    // Oversized byte counts act as a full word.
    send_key_word(rand64(), '1, 4'd15, 16'd16, 1'b1, 1'b0);
    send_key_word(rand64(), '1, 4'd9, 16'd16, 1'b0, 1'b1);
    // After a last mark the hash keeps absorbing.
    send_key_word(rand64(), rand64(), 4'd3, 16'd0, 1'b0, 1'b0);
    send_key_word(rand64(), rand64(), 4'd0, 16'd0, 1'b0, 1'b1);
    // Length not matching the delivered bytes, at the top of the range.
    send_key_word(rand64(), '1, 4'd8, 16'hffff, 1'b1, 1'b1);
    send_key_word('1, '0, 4'd8, 16'd1000, 1'b1, 1'b0);
    send_key_word('1, '0, 4'd8, 16'd1000, 1'b0, 1'b1);
    send_key_word(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 4'd8, 16'haaaa, 1'b1, 1'b0);
    send_key_word(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 4'd8, 16'h5555, 1'b0, 1'b1);
  endtask

  task automatic test_pause_until_drained();
    repeat (3) send_random_key();
    wait_all_hashes();
    send_random_key();
  endtask

  task automatic test_random_stream();
    while (beats_sent < RANDOM_BEATS) begin
      send_idle_en = ((beats_sent / 100) % 4) != 3;
      recv_stall_en = ((beats_sent / 150) % 4) != 2;
      if ($urandom_range(0, 9) < 8) send_random_key();
      else send_noise_word();
    end
  endtask

  task automatic test_back_to_back();
    send_idle_en = 1'b0;
    recv_stall_en = 1'b0;
    while (beats_sent < TOTAL_BEATS) begin
      if ($urandom_range(0, 9) < 8) send_random_key();
      else send_noise_word();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_pause_until_drained();
    test_random_stream();
    test_back_to_back();
    wait_all_hashes();
    repeat (40) @(posedge clk);
    if (hash_expect_q.size() != 0) report_mismatch("hashes never delivered", '0, '0);
    $display("Sent %0d input beats (%0d keys plus stray words), checked %0d hash beats.",
             beats_sent, keys_sent, hashes_checked);
    $display("Covered partial, empty and oversized words, masks, and missing or repeated marks.");
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
